@@ rtl/core/rfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, constants and helpers shared by the record fault decision block.
// ----------------------------------------------------------------------------
`default_nettype none
package rfd_pkg;
	localparam int unsigned BODY_LENGTH_BITS = 16;
	localparam int unsigned ORDINAL_BITS     = 32;

	localparam logic [63:0] SM_GAMMA   = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL1    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL2    = 64'h94d049bb133111eb;
	localparam logic [63:0] ORD_SALT   = 64'ha0761d6478bd642f;
	localparam logic [63:0] LANE_SALT  = 64'he7037ed1a0b428db;
	localparam logic [63:0] P_DROP     = 64'h64726f705f763031;
	localparam logic [63:0] P_DUP      = 64'h6475706c5f763031;
	localparam logic [63:0] P_MUT      = 64'h6d7574615f763031;
	localparam logic [63:0] P_MUT_OFS  = 64'h6d75746f5f763031;

	localparam logic [2:0] REG_SEED  = 3'd0;
	localparam logic [2:0] REG_DROP  = 3'd1;
	localparam logic [2:0] REG_DUP   = 3'd2;
	localparam logic [2:0] REG_EXTRA = 3'd3;
	localparam logic [2:0] REG_MUT   = 3'd4;

	typedef struct packed {
		logic [ORDINAL_BITS-1:0]     record_ordinal;
		logic [BODY_LENGTH_BITS-1:0] body_length;
	} rfd_in_t;

	typedef struct packed {
		logic                        dropped;
		logic [31:0]                 copies;
		logic                        mutate;
		logic [BODY_LENGTH_BITS-1:0] byte_offset;
		logic                        error;
	} rfd_out_t;

	// One restoring-division step for a 64-bit dividend against a divisor of
	// up to 32 bits: shift in the top dividend bit.
	function automatic logic [32:0] mod_step(input logic [32:0] rem,
		input logic bit_in, input logic [31:0] d);
		logic [33:0] sh;
		begin
			sh = {rem, bit_in};
			if (sh >= {2'b00, d})
				sh = sh - {2'b00, d};
			mod_step = sh[32:0];
		end
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/rfd_mix.sv @@
// ----------------------------------------------------------------------------
// rfd_mix
// Pipelined SplitMix64 finalizer, five register stages, 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module rfd_mix import rfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] x,
	output logic [63:0]      y
);
	logic [63:0] a_s1, b_s3, c_s5;
	logic [63:0] pl_s2, pm_s2, pl_s4, pm_s4;
	logic [63:0] ph_s2, ph_s4;

	// Each multiply by a 64-bit constant keeps the low 64 bits of three
	// 32x32 products, summed in the following stage.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= (x + SM_GAMMA) ^ ((x + SM_GAMMA) >> 30);
			pl_s2 <= 64'(a_s1[31:0] * SM_MUL1[31:0]);
			pm_s2 <= 64'(a_s1[63:32] * SM_MUL1[31:0]);
			ph_s2 <= 64'(a_s1[31:0] * SM_MUL1[63:32]);
			b_s3  <= (pl_s2 + ((pm_s2 + ph_s2) << 32)) ^
				((pl_s2 + ((pm_s2 + ph_s2) << 32)) >> 27);
			pl_s4 <= 64'(b_s3[31:0] * SM_MUL2[31:0]);
			pm_s4 <= 64'(b_s3[63:32] * SM_MUL2[31:0]);
			ph_s4 <= 64'(b_s3[31:0] * SM_MUL2[63:32]);
			c_s5  <= pl_s4 + ((pm_s4 + ph_s4) << 32);
		end
	end
	assign y = c_s5 ^ (c_s5 >> 31);
endmodule
`default_nettype wire

@@ rtl/core/record_fault_decision.sv @@
// ----------------------------------------------------------------------------
// record_fault_decision
// Per-record drop, duplicate and mutate decision from keyed SplitMix64 draws.
// ----------------------------------------------------------------------------
// channel | dir | handshake    | payload
// in      | in  | valid/stall  | in_data  (record_ordinal, body_length)
// out     | out | valid/stall  | out_data (dropped, copies, mutate, byte_offset, error)
// cfg     | in  | valid/ready  | cfg_index, cfg_data
// One record enters per cycle while in_stall is low. Two chained five-stage
// mixers, a 64-stage bit-serial modulo pipeline (one bit per stage) and the
// output register make 75 register stages. The whole pipeline advances while
// out_stall is low or out_valid is low, so a stall holds every stage. Reset
// clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none
module record_fault_decision import rfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire rfd_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output rfd_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam int unsigned L1 = 5;
	localparam int unsigned LT = 2 * L1;
	localparam int unsigned NB = 64;
	localparam int unsigned BL = BODY_LENGTH_BITS;

	logic [63:0] seed_q;
	logic [31:0] drop_q, dup_q, extra_q, mut_q;
	logic        adv;
	logic [LT-1:0] v_s;
	logic [BL-1:0] len_s [LT];
	logic [63:0] ord_mix, lane_mix;
	logic [63:0] d_drop, d_dup, d_mut, d_ofs;
	logic [63:0] ordx;

	assign adv       = !out_stall || !out_valid;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign lane_mix  = 64'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0; drop_q <= '0; dup_q <= '0; extra_q <= '0; mut_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEED:  seed_q  <= cfg_data;
				REG_DROP:  drop_q  <= cfg_data[31:0];
				REG_DUP:   dup_q   <= cfg_data[31:0];
				REG_EXTRA: extra_q <= cfg_data[31:0];
				REG_MUT:   mut_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign ordx = 64'(in_data.record_ordinal) ^ ORD_SALT;

	// Lane part is a constant: the finalizer of the lane salt for lane zero.
	logic [63:0] lane_k;
	function automatic logic [63:0] mixc(input logic [63:0] v);
		logic [63:0] t;
		begin
			t = v + SM_GAMMA;
			t = (t ^ (t >> 30)) * SM_MUL1;
			t = (t ^ (t >> 27)) * SM_MUL2;
			mixc = t ^ (t >> 31);
		end
	endfunction
	localparam logic [63:0] LANE_K = mixc(LANE_SALT);
	assign lane_k = LANE_K ^ lane_mix;

	rfd_mix u_ord (.clk(clk), .en(adv), .x(ordx), .y(ord_mix));
	logic [63:0] key;
	assign key = seed_q ^ ord_mix ^ lane_k;
	rfd_mix u_drop (.clk(clk), .en(adv), .x(key ^ P_DROP),    .y(d_drop));
	rfd_mix u_dup  (.clk(clk), .en(adv), .x(key ^ P_DUP),     .y(d_dup));
	rfd_mix u_mut  (.clk(clk), .en(adv), .x(key ^ P_MUT),     .y(d_mut));
	rfd_mix u_ofs  (.clk(clk), .en(adv), .x(key ^ P_MUT_OFS), .y(d_ofs));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[LT-2:0], in_valid};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			len_s[0] <= in_data.body_length;
			for (int i = 1; i < LT; i++) len_s[i] <= len_s[i-1];
		end
	end

	// Four modulo lanes, one dividend bit per stage.
	logic [63:0]   draw [4];
	logic [31:0]   div_c [3];
	logic [63:0]   num_m [4][1:NB];
	logic [32:0]   rem_m [4][1:NB];
	logic          vm [1:NB];
	logic [BL-1:0] lm [1:NB];
	assign draw[0]  = d_drop;
	assign draw[1]  = d_dup;
	assign draw[2]  = d_mut;
	assign draw[3]  = d_ofs;
	assign div_c[0] = drop_q;
	assign div_c[1] = dup_q;
	assign div_c[2] = mut_q;

	for (genvar s = 1; s <= NB; s++) begin : g_st
		logic          v_in;
		logic [BL-1:0] l_in;
		if (s == 1) begin : g_first
			assign v_in = v_s[LT-1];
			assign l_in = len_s[LT-1];
		end else begin : g_next
			assign v_in = vm[s-1];
			assign l_in = lm[s-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vm[s] <= 1'b0;
			else if (adv)
				vm[s] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (adv)
				lm[s] <= l_in;
		end
		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [63:0] n_in;
			logic [32:0] r_in;
			logic [31:0] dv;
			if (s == 1) begin : g_first
				assign n_in = draw[l];
				assign r_in = '0;
			end else begin : g_next
				assign n_in = num_m[l][s-1];
				assign r_in = rem_m[l][s-1];
			end
			if (l == 3) begin : g_len
				assign dv = 32'(l_in);
			end else begin : g_rate
				assign dv = div_c[l];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					num_m[l][s] <= n_in << 1;
					rem_m[l][s] <= mod_step(r_in, n_in[63], dv);
				end
			end
		end
	end

	logic        pk_drop, pk_dup, pk_mut, err, mut_ok;
	logic [32:0] cp_sum;
	logic [31:0] cp;
	rfd_out_t    res;
	assign pk_drop = (drop_q != 0) && (rem_m[0][NB] == 0);
	assign pk_dup  = (dup_q  != 0) && (rem_m[1][NB] == 0);
	assign pk_mut  = (mut_q  != 0) && (rem_m[2][NB] == 0);
	assign err     = !pk_drop && pk_mut && (lm[NB] == 0);
	assign mut_ok  = !pk_drop && pk_mut && !err;
	assign cp_sum  = 33'd1 + 33'(extra_q);
	always_comb begin
		if (pk_drop || err)
			cp = '0;
		else if (pk_dup)
			cp = cp_sum[32] ? 32'hFFFFFFFF : cp_sum[31:0];
		else
			cp = 32'd1;
	end
	always_comb begin
		res             = '0;
		res.dropped     = pk_drop;
		res.copies      = cp;
		res.mutate      = mut_ok;
		res.byte_offset = mut_ok ? rem_m[3][NB][BL-1:0] : {BL{1'b0}};
		res.error       = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= vm[NB];
	end
	always_ff @(posedge clk) begin
		if (adv)
			out_data <= res;
	end
endmodule
`default_nettype wire
